// ===== rtl/core/hpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpsd_pkg: shared constants, types and tables
// Window length, field widths, register indexes, the Q16 twiddle and Hann
// window tables and the log2 of the window energy for the spectrum block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpsd_pkg;

   localparam int WIN_LEN     = 64;
   localparam int IDX_W       = 6;
   localparam int HALF_LEN    = WIN_LEN / 2;
   localparam int SAMPLE_BITS = 16;
   localparam int SAMPLE_W    = 16;
   localparam int RATE_W      = 20;
   localparam int STRIDE_W    = 16;
   localparam int FILL_W      = 7;
   localparam int BIN_W       = 6;
   localparam int DB_W        = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 20;

   localparam int TW_W   = 18;                 // signed Q16 twiddle
   localparam int WIN_W  = 18;                 // unsigned Q17 window weight
   localparam int WORK_W = SAMPLE_W + WIN_W + 1;
   localparam int PROD_W = WORK_W + TW_W;
   localparam int ACC_W  = PROD_W + IDX_W;
   localparam int LOG_W  = 22;                 // 6 integer bits, 16 fraction bits
   localparam int SH_W   = 5;
   localparam int T_W    = 26;
   localparam int PRD_W  = 46;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_STRIDE = 4'd1;

   localparam logic [RATE_W-1:0]   RATE_RESET   = 20'd44100;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

   localparam int DB_PER_LOG2 = 197283;
   localparam logic signed [DB_W-1:0] DB_MIN = 16'sh8000;
   localparam logic signed [DB_W-1:0] DB_MAX = 16'sh7FFF;

   // sin(pi*j/32) in Q16 for j = 0 .. 16, one quarter wave.
   localparam logic [16:0] QSIN [17] = '{
      17'd0,     17'd6424,  17'd12785, 17'd19024, 17'd25080, 17'd30893,
      17'd36410, 17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798,
      17'd60547, 17'd62714, 17'd64277, 17'd65220, 17'd65536
   };

   typedef struct packed {
      logic [BIN_W-1:0]        k;
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
   } bin_type;

   function automatic logic signed [TW_W-1:0] cos_tw(input logic [IDX_W-1:0] m);
      logic [4:0] j;
      logic [4:0] jc;
      logic signed [TW_W-1:0] a;
      logic signed [TW_W-1:0] b;
      j  = {1'b0, m[3:0]};
      jc = 5'd16 - j;
      a  = $signed({1'b0, QSIN[jc]});
      b  = $signed({1'b0, QSIN[j]});
      case (m[5:4])
         2'd0:    cos_tw = a;
         2'd1:    cos_tw = -b;
         2'd2:    cos_tw = -a;
         default: cos_tw = b;
      endcase
   endfunction

   function automatic logic signed [TW_W-1:0] sin_tw(input logic [IDX_W-1:0] m);
      logic [4:0] j;
      logic [4:0] jc;
      logic signed [TW_W-1:0] a;
      logic signed [TW_W-1:0] b;
      j  = {1'b0, m[3:0]};
      jc = 5'd16 - j;
      a  = $signed({1'b0, QSIN[jc]});
      b  = $signed({1'b0, QSIN[j]});
      case (m[5:4])
         2'd0:    sin_tw = b;
         2'd1:    sin_tw = a;
         2'd2:    sin_tw = -b;
         default: sin_tw = -a;
      endcase
   endfunction

   // Periodic Hann weight 1 - cos, in Q17.
   function automatic logic [WIN_W-1:0] win_coef(input logic [IDX_W-1:0] m);
      logic signed [TW_W-1:0] c;
      logic signed [TW_W:0]   w;
      c = cos_tw(m);
      w = 19'sd65536 - {c[TW_W-1], c};
      win_coef = w[WIN_W-1:0];
   endfunction

   function automatic logic [63:0] win_energy();
      logic [63:0] e;
      logic [63:0] w;
      e = '0;
      for (int m = 0; m < WIN_LEN; m++) begin
         w = {46'd0, win_coef(IDX_W'(m))};
         e = e + w * w;
      end
      win_energy = e;
   endfunction

   function automatic logic [LOG_W-1:0] const_log2(input logic [63:0] x);
      int p;
      logic [63:0] m;
      logic [63:0] mm;
      logic [15:0] f;
      p = 0;
      f = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = i;
         end
      end
      m = (x << (63 - p)) >> 32;
      for (int i = 0; i < 16; i++) begin
         mm = (m * m) >> 31;
         if (mm[32]) begin
            f = {f[14:0], 1'b1};
            m = mm >> 1;
         end else begin
            f = {f[14:0], 1'b0};
            m = mm;
         end
      end
      const_log2 = {p[5:0], f};
   endfunction

   localparam logic [LOG_W-1:0] LOG_ENERGY = const_log2(win_energy());

endpackage

`default_nettype wire

// ===== rtl/core/hpsd_req_if.sv =====
// ----------------------------------------------------------------------------
// hpsd_req_if: sample channel
// Valid/ready channel carrying one audio sample and its restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpsd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [hpsd_pkg::SAMPLE_W-1:0]  sample;
   logic                                  restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hpsd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hpsd_rsp_if: spectrum bin channel
// Valid/ready channel carrying one bin of a power spectrum in dB.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpsd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hpsd_pkg::BIN_W-1:0]        bin_index;
   logic signed [hpsd_pkg::DB_W-1:0]  power_db;
   logic                              last_bin;

   modport source (output valid, output bin_index, output power_db, output last_bin,
                   input ready);
   modport sink   (input valid, input bin_index, input power_db, input last_bin,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hpsd_ram.sv =====
// ----------------------------------------------------------------------------
// hpsd_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hpsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/hpsd_dft.sv =====
// ----------------------------------------------------------------------------
// hpsd_dft: windowing and bin accumulation
// Holds the sample ring, writes windowed samples to the work store and then
// accumulates one bin at a time with a single complex multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module hpsd_dft (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic signed [hpsd_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic                                start,
   output logic                                     busy,
   output logic                                     bin_valid,
   input  wire logic                                bin_ready,
   output hpsd_pkg::bin_type                        bin
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WIN   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;

   localparam int IW = hpsd_pkg::IDX_W;
   localparam int AW = hpsd_pkg::ACC_W;
   localparam int PW = hpsd_pkg::PROD_W;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] head_ff;
   logic          issue, clear;

   logic          s1_ff, s1_win_ff, s2_ff;
   logic [IW-1:0] s1_n_ff;
   logic signed [PW-1:0] pre_ff, pim_ff;
   logic signed [AW-1:0] acc_re_ff, acc_im_ff;

   logic signed [hpsd_pkg::SAMPLE_W-1:0] ring_q;
   logic signed [hpsd_pkg::WORK_W-1:0]   work_d, work_q;
   logic [IW-1:0] ring_raddr;
   logic [IW-1:0] idx;

   hpsd_ram #(.WIDTH(hpsd_pkg::SAMPLE_W), .DEPTH(hpsd_pkg::WIN_LEN)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_ff),
      .wr_data (wr_data),
      .rd_addr (ring_raddr),
      .rd_data (ring_q)
   );

   hpsd_ram #(.WIDTH(hpsd_pkg::WORK_W), .DEPTH(hpsd_pkg::WIN_LEN)) u_work (
      .clock   (clock),
      .wr_en   (s1_ff & s1_win_ff),
      .wr_addr (s1_n_ff),
      .wr_data (work_d),
      .rd_addr (cnt_ff),
      .rd_data (work_q)
   );

   // The oldest sample sits at the write pointer.
   assign ring_raddr = head_ff + cnt_ff;
   assign idx        = k_ff * cnt_ff;
   assign work_d     = ring_q * $signed({1'b0, hpsd_pkg::win_coef(s1_n_ff)});

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      issue    = 1'b0;
      clear    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WIN;
               cnt_in   = '0;
            end
         end
         ST_WIN: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(hpsd_pkg::WIN_LEN - 1)) begin
               state_in = ST_ACC;
               k_in     = '0;
               clear    = 1'b1;
            end
         end
         ST_ACC: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(hpsd_pkg::WIN_LEN - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (bin_ready) begin
               if (k_ff == IW'(hpsd_pkg::HALF_LEN)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ACC;
                  k_in     = k_ff + 1'b1;
                  cnt_in   = '0;
                  clear    = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            head_ff <= head_ff + 1'b1;
         end
         s1_ff <= issue;
         s2_ff <= s1_ff & ~s1_win_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      s1_win_ff <= (state_ff == ST_WIN);
      s1_n_ff   <= (state_ff == ST_WIN) ? cnt_ff : idx;
      pre_ff    <= work_q * hpsd_pkg::cos_tw(s1_n_ff);
      pim_ff    <= work_q * hpsd_pkg::sin_tw(s1_n_ff);
      if (clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (s2_ff) begin
         acc_re_ff <= acc_re_ff + {{(AW - PW){pre_ff[PW-1]}}, pre_ff};
         acc_im_ff <= acc_im_ff - {{(AW - PW){pim_ff[PW-1]}}, pim_ff};
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign bin_valid = (state_ff == ST_HOLD);
   assign bin.k     = k_ff;
   assign bin.re    = acc_re_ff;
   assign bin.im    = acc_im_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hpsd_log2.sv =====
// ----------------------------------------------------------------------------
// hpsd_log2: iterative base-2 logarithm
// Finds the leading one one bit per cycle, then produces sixteen fraction
// bits by repeated squaring of the normalized mantissa.
// ----------------------------------------------------------------------------
`default_nettype none

module hpsd_log2 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [63:0]                   operand,
   output logic                               done,
   output logic [hpsd_pkg::LOG_W-1:0]         result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_NORM = 2'd1;
   localparam logic [1:0] ST_SQR  = 2'd2;

   logic [1:0]  state_ff;
   logic        done_ff;
   logic [63:0] x_ff;
   logic [5:0]  p_ff;
   logic [31:0] m_ff;
   logic [15:0] f_ff;
   logic [3:0]  cnt_ff;
   logic [63:0] mm;

   assign mm = {32'd0, m_ff} * {32'd0, m_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (x_ff[63]) begin
                  state_ff <= ST_SQR;
               end
            end
            ST_SQR: begin
               if (cnt_ff == 4'd15) begin
                  state_ff <= ST_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff <= operand;
            p_ff <= 6'd63;
         end
         ST_NORM: begin
            if (x_ff[63]) begin
               m_ff   <= x_ff[63:32];
               f_ff   <= '0;
               cnt_ff <= '0;
            end else begin
               x_ff <= x_ff << 1;
               p_ff <= p_ff - 1'b1;
            end
         end
         ST_SQR: begin
            // The squared mantissa reaching two yields a one bit and a halving.
            f_ff   <= {f_ff[14:0], mm[63]};
            m_ff   <= mm[63] ? mm[63:32] : mm[62:31];
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign done   = done_ff;
   assign result = {p_ff, f_ff};

endmodule

`default_nettype wire

// ===== rtl/core/hpsd_db.sv =====
// ----------------------------------------------------------------------------
// hpsd_db: bin power to decibels
// Scales one bin, forms its power, takes logs of the power and the sample
// rate and converts to 1/256 dB, then holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpsd_db (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              bin_valid,
   output logic                                   bin_ready,
   input  wire hpsd_pkg::bin_type                 bin,
   input  wire logic [hpsd_pkg::RATE_W-1:0]       sample_rate,
   output logic                                   busy,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [hpsd_pkg::BIN_W-1:0]             rsp_bin_index,
   output logic signed [hpsd_pkg::DB_W-1:0]       rsp_power_db,
   output logic                                   rsp_last_bin
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCALE  = 4'd1;
   localparam logic [3:0] ST_SQUARE = 4'd2;
   localparam logic [3:0] ST_LOGP   = 4'd3;
   localparam logic [3:0] ST_WAITP  = 4'd4;
   localparam logic [3:0] ST_LOGF   = 4'd5;
   localparam logic [3:0] ST_WAITF  = 4'd6;
   localparam logic [3:0] ST_TSUM   = 4'd7;
   localparam logic [3:0] ST_MUL    = 4'd8;
   localparam logic [3:0] ST_SAT    = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   localparam int AW = hpsd_pkg::ACC_W;
   localparam int LW = hpsd_pkg::LOG_W;
   localparam int TW = hpsd_pkg::T_W;
   localparam int QW = hpsd_pkg::PRD_W - 24;

   logic [3:0]    state_ff;
   logic [AW-1:0] ar_ff, ai_ff;
   logic [hpsd_pkg::BIN_W-1:0] k_ff;
   logic [hpsd_pkg::SH_W-1:0]  sh_ff;
   logic [61:0]   sqa_ff, sqb_ff;
   logic [LW-1:0] lp_ff, lf_ff;
   logic signed [TW-1:0] t_ff, t_calc;
   logic signed [hpsd_pkg::PRD_W-1:0] prod_ff;
   logic signed [hpsd_pkg::DB_W-1:0]  db_ff;
   logic signed [QW-1:0] q;
   logic signed [7:0]    ex;
   logic          dbl;
   logic          rsp_valid_ff;
   logic [AW-1:0] mag_re, mag_im;
   logic [hpsd_pkg::RATE_W-1:0] fs;
   logic          log_start, log_done;
   logic [63:0]   log_operand;
   logic [LW-1:0] log_result;

   hpsd_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .operand (log_operand),
      .done    (log_done),
      .result  (log_result)
   );

   assign mag_re = bin.re[AW-1] ? AW'(-bin.re) : AW'(bin.re);
   assign mag_im = bin.im[AW-1] ? AW'(-bin.im) : AW'(bin.im);
   assign fs     = (sample_rate == '0) ? hpsd_pkg::RATE_W'(1) : sample_rate;

   assign log_start   = (state_ff == ST_LOGP) || (state_ff == ST_LOGF);
   assign log_operand = (state_ff == ST_LOGP) ? {1'b0, 63'(sqa_ff) + 63'(sqb_ff)}
                                              : {44'd0, fs};

   // Interior bins carry the one-sided doubling.
   assign dbl = (k_ff != '0) && (k_ff < hpsd_pkg::BIN_W'(hpsd_pkg::HALF_LEN));
   assign ex  = $signed({2'b00, sh_ff, 1'b0}) + (dbl ? 8'sd1 : 8'sd0) - 8'sd32;
   assign t_calc = $signed({4'd0, lp_ff}) - $signed({4'd0, lf_ff})
                 - $signed({4'd0, hpsd_pkg::LOG_ENERGY})
                 + $signed({{(TW - 24){ex[7]}}, ex, 16'd0});
   assign q = QW'(prod_ff >>> 24);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (bin_valid) begin
                  state_ff <= (bin.re == '0 && bin.im == '0) ? ST_OUT : ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (~|(ar_ff[AW-1:31] | ai_ff[AW-1:31])) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: state_ff <= ST_LOGP;
            ST_LOGP:   state_ff <= ST_WAITP;
            ST_WAITP: begin
               if (log_done) begin
                  state_ff <= ST_LOGF;
               end
            end
            ST_LOGF:   state_ff <= ST_WAITF;
            ST_WAITF: begin
               if (log_done) begin
                  state_ff <= ST_TSUM;
               end
            end
            ST_TSUM:   state_ff <= ST_MUL;
            ST_MUL:    state_ff <= ST_SAT;
            ST_SAT:    state_ff <= ST_OUT;
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ar_ff <= mag_re;
            ai_ff <= mag_im;
            k_ff  <= bin.k;
            sh_ff <= '0;
            db_ff <= hpsd_pkg::DB_MIN;
         end
         ST_SCALE: begin
            if (|(ar_ff[AW-1:31] | ai_ff[AW-1:31])) begin
               ar_ff <= ar_ff >> 1;
               ai_ff <= ai_ff >> 1;
               sh_ff <= sh_ff + 1'b1;
            end
         end
         ST_SQUARE: begin
            sqa_ff <= {31'd0, ar_ff[30:0]} * {31'd0, ar_ff[30:0]};
            sqb_ff <= {31'd0, ai_ff[30:0]} * {31'd0, ai_ff[30:0]};
         end
         ST_WAITP: begin
            if (log_done) begin
               lp_ff <= log_result;
            end
         end
         ST_WAITF: begin
            if (log_done) begin
               lf_ff <= log_result;
            end
         end
         ST_TSUM: t_ff <= t_calc;
         ST_MUL: begin
            prod_ff <= t_ff * $signed(19'(hpsd_pkg::DB_PER_LOG2))
                     + $signed(hpsd_pkg::PRD_W'(24'h800000));
         end
         ST_SAT: begin
            if (q > QW'(signed'(hpsd_pkg::DB_MAX))) begin
               db_ff <= hpsd_pkg::DB_MAX;
            end else if (q < QW'(signed'(hpsd_pkg::DB_MIN))) begin
               db_ff <= hpsd_pkg::DB_MIN;
            end else begin
               db_ff <= q[hpsd_pkg::DB_W-1:0];
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_bin_index <= k_ff;
               rsp_power_db  <= db_ff;
               rsp_last_bin  <= (k_ff == hpsd_pkg::BIN_W'(hpsd_pkg::HALF_LEN));
            end
         end
         default: ;
      endcase
   end

   assign bin_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hann_power_spectrum_db.sv =====
// ----------------------------------------------------------------------------
// hann_power_spectrum_db: sliding Hann-windowed power spectrum in dB
// Keeps the last 64 samples in a ring memory and emits 33 bins of power
// spectral density, in 1/256 dB, each time a spectrum is due.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                           Handshake
//   req_chan  in         sample (s16), restart             valid / ready
//   rsp_chan  out        bin_index, power_db (s16), last   valid / ready
//   csr_*     in         csr_index, csr_wdata              csr_we, no stall
//
// A sample that does not complete a spectrum leaves the block ready for the
// next one. A sample that does starts a window pass over the whole ring,
// then the multiply-accumulate of the first bin. Each later bin accumulates
// while the previous one is converted, and a conversion scales the bin and
// runs the logarithm unit twice; the single multiply-accumulate unit and the
// bit-serial log unit set the pace of a spectrum. There is no clearing pass
// after reset. Stalls on the result channel hold the bin pipeline; samples
// are refused until the spectrum is fully computed, while the last result
// may still wait in its register.
//
`default_nettype none

module hann_power_spectrum_db (
   input  wire logic                                clock,
   input  wire logic                                reset,
   hpsd_req_if.sink                                 req_chan,
   hpsd_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [hpsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [hpsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FW = hpsd_pkg::FILL_W;
   localparam int SW = hpsd_pkg::STRIDE_W;

   logic [hpsd_pkg::RATE_W-1:0] rate_ff;
   logic [SW-1:0] stride_ff;
   logic [FW-1:0] fill_ff, fill_in, fill_base;
   logic [SW-1:0] phase_ff, phase_in, phase_base, phase_inc;
   logic [SW-1:0] stride_eff;
   logic          accept, emit;
   logic          dft_busy, db_busy;
   logic          bin_valid, bin_ready;
   hpsd_pkg::bin_type bin;

   // Configuration registers; writes to other indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= hpsd_pkg::RATE_RESET;
         stride_ff <= hpsd_pkg::STRIDE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hpsd_pkg::CSR_SAMPLE_RATE:   rate_ff   <= csr_wdata;
            hpsd_pkg::CSR_WINDOW_STRIDE: stride_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // Samples are taken only while no spectrum is being computed.
   assign req_chan.ready = !dft_busy && !db_busy;
   assign accept         = req_chan.valid && req_chan.ready;

   // Fill and stride bookkeeping. The first full window always emits, and
   // after that a spectrum follows each time the phase reaches the stride.
   // A zero stride behaves as a stride of one.
   assign stride_eff = (stride_ff == '0) ? SW'(1) : stride_ff;
   assign fill_base  = req_chan.restart ? '0 : fill_ff;
   assign phase_base = req_chan.restart ? '0 : phase_ff;
   assign phase_inc  = (phase_base == '1) ? phase_base : phase_base + 1'b1;

   always_comb begin
      if (fill_base < FW'(hpsd_pkg::WIN_LEN)) begin
         fill_in  = fill_base + 1'b1;
         emit     = (fill_in == FW'(hpsd_pkg::WIN_LEN));
         phase_in = emit ? '0 : phase_base;
      end else begin
         fill_in  = fill_base;
         emit     = (phase_inc >= stride_eff);
         phase_in = emit ? '0 : phase_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         phase_ff <= '0;
      end else if (accept) begin
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
      end
   end

   // The sample is written to the ring at the same edge at which the window
   // pass starts, so the pass already sees it.
   hpsd_dft u_dft (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_data   (req_chan.sample[hpsd_pkg::SAMPLE_BITS-1:0]),
      .start     (accept && emit),
      .busy      (dft_busy),
      .bin_valid (bin_valid),
      .bin_ready (bin_ready),
      .bin       (bin)
   );

   hpsd_db u_db (
      .clock         (clock),
      .reset         (reset),
      .bin_valid     (bin_valid),
      .bin_ready     (bin_ready),
      .bin           (bin),
      .sample_rate   (rate_ff),
      .busy          (db_busy),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_bin_index (rsp_chan.bin_index),
      .rsp_power_db  (rsp_chan.power_db),
      .rsp_last_bin  (rsp_chan.last_bin)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for hann_power_spectrum_db
// Sends sample streams through the spectrum block under several register
// settings. Expected dB bins come from a predictor written in fixed point. Each
// bin that arrives is checked against the oldest expected bin, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   // Clock, reset and the channels to the block.
   logic clock;
   logic reset;
   logic csr_we;
   logic [hpsd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [hpsd_pkg::CSR_DATA_W-1:0] csr_wdata;

   hpsd_req_if req_chan();
   hpsd_rsp_if rsp_chan();

   hann_power_spectrum_db dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   typedef struct {
      logic signed [hpsd_pkg::SAMPLE_W-1:0] sample;
      logic                                 restart;
   } sample_item_type;

   typedef struct {
      logic [hpsd_pkg::BIN_W-1:0]        bin_index;
      logic signed [hpsd_pkg::DB_W-1:0]  power_db;
      logic                              last_bin;
   } db_bin_type;

   sample_item_type pending_samples[$];
   db_bin_type      expected_bins[$];
   int              error_count = 0;

   // Twiddle and window tables of the predictor, built once at time zero.
   int          cos_q16 [hpsd_pkg::WIN_LEN];
   int          sin_q16 [hpsd_pkg::WIN_LEN];
   longint      hann_q17[hpsd_pkg::WIN_LEN];
   logic [63:0] hann_energy;

   // Shadow copy of the registers and of the sliding window state.
   logic [hpsd_pkg::RATE_W-1:0]    rate_shadow;
   logic [hpsd_pkg::STRIDE_W-1:0]  stride_shadow;
   logic signed [hpsd_pkg::SAMPLE_W-1:0] window_ring[hpsd_pkg::WIN_LEN];
   int                   samples_since_restart;
   int                   samples_since_spectrum;

   // The Hann table uses a truncating Taylor series on the angle within one
   // quadrant, rounded to Q16, with the quadrant's sign applied after.
   function automatic void build_trig_tables();
      logic [63:0] ang;
      logic [63:0] x2;
      logic [63:0] tc;
      logic [63:0] ts;
      longint      sc;
      longint      ss;
      logic [63:0] cq;
      logic [63:0] sq;
      int          quad;
      int          rem;
      hann_energy = 0;
      for (int m = 0; m < hpsd_pkg::WIN_LEN; m++) begin
         quad = (4 * m) / hpsd_pkg::WIN_LEN;
         rem  = 4 * m - quad * hpsd_pkg::WIN_LEN;
         ang  = 64'd1686629713 * rem / hpsd_pkg::WIN_LEN;
         x2   = (ang * ang) >> 30;
         tc   = 64'd1073741824;
         ts   = ang;
         sc   = 64'd1073741824;
         ss   = ang;
         for (int j = 1; j <= 8; j++) begin
            tc = ((tc * x2) >> 30) / ((2 * j - 1) * (2 * j));
            ts = ((ts * x2) >> 30) / ((2 * j) * (2 * j + 1));
            if (j % 2 == 1) begin
               sc -= longint'(tc);
               ss -= longint'(ts);
            end else begin
               sc += longint'(tc);
               ss += longint'(ts);
            end
         end
         cq = (sc < 0) ? 0 : (sc > 1073741824) ? 64'd1073741824 : sc;
         sq = (ss < 0) ? 0 : (ss > 1073741824) ? 64'd1073741824 : ss;
         cq = (cq + 8192) >> 14;
         sq = (sq + 8192) >> 14;
         case (quad)
            0: begin cos_q16[m] = int'(cq);  sin_q16[m] = int'(sq);  end
            1: begin cos_q16[m] = -int'(sq); sin_q16[m] = int'(cq);  end
            2: begin cos_q16[m] = -int'(cq); sin_q16[m] = -int'(sq); end
            default: begin cos_q16[m] = int'(sq); sin_q16[m] = -int'(cq); end
         endcase
         hann_q17[m] = 65536 - longint'(cos_q16[m]);
         hann_energy += hann_q17[m] * hann_q17[m];
      end
   endfunction

   // Base-2 logarithm in Q16 by repeated squaring of a normalized mantissa.
   function automatic longint log2_fixed(input logic [63:0] x);
      int          p;
      logic [63:0] mant;
      longint      frac;
      p = 63;
      frac = 0;
      while (p > 0 && !x[p]) p--;
      mant = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      for (int i = 0; i < 16; i++) begin
         mant = (mant * mant) >> 31;
         if (mant >= 64'h1_0000_0000) begin
            frac = frac * 2 + 1;
            mant = mant >> 1;
         end else begin
            frac = frac * 2;
         end
      end
      return longint'(p) * 65536 + frac;
   endfunction

   function automatic logic signed [hpsd_pkg::DB_W-1:0] bin_density_db(input longint re,
                                                                       input longint im,
                                                                       input bit doubled);
      logic [63:0] ar;
      logic [63:0] ai;
      logic [63:0] mx;
      logic [63:0] pw;
      longint      t;
      longint      q;
      int          sh;
      logic [63:0] fs;
      ar = (re < 0) ? -re : re;
      ai = (im < 0) ? -im : im;
      mx = (ar > ai) ? ar : ai;
      fs = (rate_shadow == 0) ? 64'd1 : 64'(rate_shadow);
      sh = 0;
      // Zero power has no logarithm; it saturates to the lowest code.
      if (mx == 0) return hpsd_pkg::DB_MIN;
      while ((mx >> sh) >= 64'h8000_0000) sh++;
      ar = ar >> sh;
      ai = ai >> sh;
      pw = ar * ar + ai * ai;
      t = log2_fixed(pw) - log2_fixed(fs) - log2_fixed(hann_energy)
          + longint'(2 * sh - 32 + (doubled ? 1 : 0)) * 65536;
      t = t * 197283 + 8388608;
      if (t >= 0) q = t >>> 24;
      else q = -((-t + 16777215) >>> 24);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[hpsd_pkg::DB_W-1:0];
   endfunction

   function automatic void predict_spectrum();
      longint     windowed[hpsd_pkg::WIN_LEN];
      longint     re;
      longint     im;
      db_bin_type b;
      for (int n = 0; n < hpsd_pkg::WIN_LEN; n++)
         windowed[n] = longint'(window_ring[n]) * hann_q17[n];
      for (int k = 0; k <= hpsd_pkg::HALF_LEN; k++) begin
         re = 0;
         im = 0;
         for (int n = 0; n < hpsd_pkg::WIN_LEN; n++) begin
            re += windowed[n] * cos_q16[(k * n) % hpsd_pkg::WIN_LEN];
            im -= windowed[n] * sin_q16[(k * n) % hpsd_pkg::WIN_LEN];
         end
         b.bin_index = hpsd_pkg::BIN_W'(k);
         // The Nyquist bin is handled like bin 0: not doubled.
         b.power_db  = bin_density_db(re, im, k > 0 && 2 * k < hpsd_pkg::WIN_LEN);
         b.last_bin  = (k == hpsd_pkg::HALF_LEN);
         expected_bins.push_back(b);
      end
   endfunction

   function automatic void predict_sample(input sample_item_type it);
      int stride;
      stride = (stride_shadow == 0) ? 1 : int'(stride_shadow);
      if (it.restart) begin
         samples_since_restart  = 0;
         samples_since_spectrum = 0;
      end
      for (int n = 0; n < hpsd_pkg::WIN_LEN - 1; n++) window_ring[n] = window_ring[n + 1];
      window_ring[hpsd_pkg::WIN_LEN - 1] = it.sample;
      if (samples_since_restart < hpsd_pkg::WIN_LEN) begin
         samples_since_restart++;
         // The first full window after a restart always yields a spectrum.
         if (samples_since_restart == hpsd_pkg::WIN_LEN) begin
            samples_since_spectrum = 0;
            predict_spectrum();
         end
      end else begin
         if (samples_since_spectrum < 65535) samples_since_spectrum++;
         // A lowered stride that is already reached fires on this sample.
         if (samples_since_spectrum >= stride) begin
            samples_since_spectrum = 0;
            predict_spectrum();
         end
      end
   endfunction

   // Sample side: the monitor records each transaction at the rising edge, and
   // the driver acts on that record at the next falling edge.
   bit req_taken;
   bit rsp_taken;
   int req_gap;

   always @(posedge clock) begin
      sample_item_type it;
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         it.sample  = req_chan.sample;
         it.restart = req_chan.restart;
         predict_sample(it);
      end
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   always @(negedge clock) begin
      sample_item_type it;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.sample  <= '0;
         req_chan.restart <= 1'b0;
         req_gap = 0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_taken) req_gap = random_gap();
         if (req_gap > 0 || pending_samples.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_chan.valid <= 1'b0;
         end else begin
            it = pending_samples.pop_front();
            req_chan.valid   <= 1'b1;
            req_chan.sample  <= it.sample;
            req_chan.restart <= it.restart;
         end
      end
   end

   // Result side: checking at the rising edge, ready driven at the falling edge.
   bit long_hold_armed = 0;
   int rsp_hold;
   int quiet_stretch;

   always @(posedge clock) begin
      db_bin_type e;
      rsp_taken = !reset && rsp_chan.valid && rsp_chan.ready;
      if (rsp_taken) begin
         if (expected_bins.size() == 0) begin
            $error("unexpected bin %0d with power %0d", rsp_chan.bin_index, rsp_chan.power_db);
            error_count++;
         end else begin
            e = expected_bins.pop_front();
            if (rsp_chan.bin_index !== e.bin_index) begin
               $error("bin_index: expected %0d, got %0d", e.bin_index, rsp_chan.bin_index);
               error_count++;
            end
            if (rsp_chan.power_db !== e.power_db) begin
               $error("power_db: expected %0d, got %0d", e.power_db, rsp_chan.power_db);
               error_count++;
            end
            if (rsp_chan.last_bin !== e.last_bin) begin
               $error("last_bin: expected %0d, got %0d", e.last_bin, rsp_chan.last_bin);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
         quiet_stretch = 0;
      end else begin
         if (rsp_taken && long_hold_armed) begin
            // One long hold-off while the sender keeps offering samples.
            long_hold_armed = 0;
            rsp_hold = 3000;
         end else if (rsp_hold == 0 && rsp_taken) begin
            if (quiet_stretch > 0) quiet_stretch--;
            else if ($urandom_range(0, 49) == 0) quiet_stretch = $urandom_range(30, 80);
            else rsp_hold = random_gap();
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction on either channel.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (req_taken || rsp_taken || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic push_sample(input int value, input bit restart);
      sample_item_type it;
      it.sample  = value[hpsd_pkg::SAMPLE_W-1:0];
      it.restart = restart;
      pending_samples.push_back(it);
   endtask

   task automatic push_random_run(input int count);
      int shape;
      shape = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) begin
         case (shape)
            0: push_sample($urandom, 1'b0);
            1: push_sample($signed(16'($urandom_range(0, 511))) - 256, 1'b0);
            2: push_sample((i % 2) ? 32767 - $urandom_range(0, 3) : -32768, 1'b0);
            default: push_sample((i % 8 < 4) ? $urandom_range(0, 32767)
                                             : -$urandom_range(1, 32768), 1'b0);
         endcase
      end
   endtask

   // Lets the block drain, plus a short margin for a sample that is still
   // being taken without causing a spectrum.
   task automatic wait_for_idle();
      while (pending_samples.size() != 0 || req_chan.valid || expected_bins.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(input logic [hpsd_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[hpsd_pkg::CSR_DATA_W-1:0];
      if (idx == hpsd_pkg::CSR_SAMPLE_RATE) rate_shadow = value[hpsd_pkg::RATE_W-1:0];
      else if (idx == hpsd_pkg::CSR_WINDOW_STRIDE)
         stride_shadow = value[hpsd_pkg::STRIDE_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid   = 1'b0;
      req_chan.sample  = '0;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
      rate_shadow   = hpsd_pkg::RATE_RESET;
      stride_shadow = hpsd_pkg::STRIDE_RESET;
      samples_since_restart  = 0;
      samples_since_spectrum = 0;
      build_trig_tables();
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset register values. A restart partway through the fill, then a
      // silent window whose spectrum is all zero power.
      for (int i = 0; i < 10; i++) push_sample(32767, i == 0);
      for (int i = 0; i < hpsd_pkg::WIN_LEN; i++) push_sample(0, i == 0);
      // Extremes, a full-scale alternating tone for the Nyquist bin, and DC.
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b0);
      push_sample(1, 1'b0);
      push_sample(-1, 1'b0);
      for (int i = 0; i < 28; i++) push_sample((i % 2) ? 32767 : -32768, 1'b0);
      for (int i = 0; i < 32; i++) push_sample(-32768, 1'b0);
      wait_for_idle();

      // Lowest rate and stride, with a long hold-off on the result side.
      write_register(hpsd_pkg::CSR_SAMPLE_RATE, 1);
      write_register(hpsd_pkg::CSR_WINDOW_STRIDE, 1);
      long_hold_armed = 1;
      push_sample($urandom, 1'b1);
      push_random_run(hpsd_pkg::WIN_LEN + 8);
      wait_for_idle();

      // Zero in both registers acts as one; an unknown index is ignored.
      write_register(hpsd_pkg::CSR_SAMPLE_RATE, 0);
      write_register(hpsd_pkg::CSR_WINDOW_STRIDE, 0);
      write_register(hpsd_pkg::CSR_IDX_W'(5), 12345);
      push_random_run(3);
      wait_for_idle();

      // Highest values, then a lowered stride that is already reached.
      write_register(hpsd_pkg::CSR_SAMPLE_RATE, 1048575);
      write_register(hpsd_pkg::CSR_WINDOW_STRIDE, 65535);
      push_sample($urandom, 1'b1);
      push_random_run(hpsd_pkg::WIN_LEN + 9);
      wait_for_idle();
      write_register(hpsd_pkg::CSR_SAMPLE_RATE, 1000000);
      write_register(hpsd_pkg::CSR_WINDOW_STRIDE, 5);
      push_random_run(6);
      wait_for_idle();

      // Random settings: a restart plus a full window of random content,
      // with occasional stray restarts inside the run.
      write_register(hpsd_pkg::CSR_SAMPLE_RATE, $urandom_range(1, 1000000));
      write_register(hpsd_pkg::CSR_WINDOW_STRIDE, $urandom_range(6, 40));
      push_sample($urandom, 1'b1);
      push_random_run(hpsd_pkg::WIN_LEN - 1);
      for (int i = 0; i < 30; i++) push_sample($urandom, $urandom_range(0, 39) == 0);
      wait_for_idle();

      repeat (500) @(posedge clock);
      if (error_count == 0 && expected_bins.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
